/* rtl/core/cylinder_mesh_index_generator_defines.svh */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator assertion macros
// Concurrent check macros shared by the RTL files that carry assertions.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_MESH_INDEX_GENERATOR_DEFINES_SVH
`define CYLINDER_MESH_INDEX_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks that a property holds at every clock edge outside reset.
`define CMIG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cylinder mesh index check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define CMIG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cylinder mesh index sequence check failed");
`else
`define CMIG_ASSERT(label, clk, rst, prop)
`define CMIG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/cmig_pkg.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator package
// Shared widths, codes, types and reset values.
// ----------------------------------------------------------------------------
package cmig_pkg;

  localparam int CNT_W     = 8;   // ring and slice count registers
  localparam int POS_W     = 7;   // ring and slice position counters
  localparam int VTX_W     = 16;  // vertex index width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam int MAX_RINGS_DEF  = 128;
  localparam int MAX_SLICES_DEF = 128;

  localparam logic [CNT_W-1:0] RING_MIN    = 8'd2;
  localparam logic [CNT_W-1:0] SLICE_MIN   = 8'd1;
  localparam logic [CNT_W-1:0] RING_RESET  = 8'd16;
  localparam logic [CNT_W-1:0] SLICE_RESET = 8'd16;

  typedef enum logic [1:0] {
    PART_SIDE   = 2'd0,
    PART_BOTTOM = 2'd1,
    PART_TOP    = 2'd2
  } part_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT      = 2'd0,
    CFG_SLICE_COUNT     = 2'd1,
    CFG_LENGTH_NEGATIVE = 2'd2
  } cfg_reg_t;

  // Effective (saturated) configuration.
  typedef struct packed {
    logic [CNT_W-1:0] rings;
    logic [CNT_W-1:0] slices;
    logic             length_negative;
  } cfg_t;

  // Walk position through the mesh.
  typedef struct packed {
    part_t            part;
    logic [POS_W-1:0] ring;
    logic [POS_W-1:0] slice;
    logic             second_half;
    logic [VTX_W-1:0] base;
  } pos_t;

  localparam pos_t POS_CLEAR = '{
    part:        PART_SIDE,
    ring:        '0,
    slice:       '0,
    second_half: 1'b0,
    base:        '0
  };

endpackage

/* rtl/core/cmig_req_if.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator request channel
// Carries the restart flag of one triangle request.
// ----------------------------------------------------------------------------
interface cmig_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

/* rtl/core/cmig_rsp_if.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator result channel
// Carries one triangle: three vertex indices, mesh part and last flag.
// ----------------------------------------------------------------------------
interface cmig_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cmig_pkg::VTX_W-1:0]    first_vertex;
  logic [cmig_pkg::VTX_W-1:0]    second_vertex;
  logic [cmig_pkg::VTX_W-1:0]    third_vertex;
  logic [1:0]                    mesh_part;
  logic                          last_triangle;

  modport source (output valid, output first_vertex, output second_vertex,
                  output third_vertex, output mesh_part, output last_triangle,
                  input ready);
  modport sink   (input valid, input first_vertex, input second_vertex,
                  input third_vertex, input mesh_part, input last_triangle,
                  output ready);
endinterface

/* rtl/core/cmig_cfg_if.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator configuration channel
// Register write requests: register index and write data.
// ----------------------------------------------------------------------------
interface cmig_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cmig_pkg::CFG_IDX_W-1:0]   index;
  logic [cmig_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/cylinder_mesh_index_generator.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator
// Streams the triangle index list of a cylinder mesh, one triangle a request.
// ----------------------------------------------------------------------------
// Every accepted request returns the next triangle of the mesh as three
// 16-bit vertex indices, walking the side quads ring by ring, then the
// bottom cap and finally the top cap, after which it wraps back to the first
// side triangle. A request with restart set begins the walk at the first
// side triangle. The block takes one request per clock cycle and answers
// each one in the following cycle: the position counters and index adders sit
// between the position registers and one result register, and the request
// side stays ready whenever that result register is empty or being drained
// in the same cycle. Counts outside their legal range are clamped, and the
// configuration registers should only be written while no triangle is in
// flight; no reset sweep is needed, so requests are taken from the first
// cycle after reset.
// ----------------------------------------------------------------------------
`include "cylinder_mesh_index_generator_defines.svh"

module cylinder_mesh_index_generator #(
  parameter int MAX_RINGS  = cmig_pkg::MAX_RINGS_DEF,
  parameter int MAX_SLICES = cmig_pkg::MAX_SLICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cmig_req_if.sink  req,
  cmig_rsp_if.source rsp,
  cmig_cfg_if.sink  cfg
);

  cmig_pkg::cfg_t                 eff;
  cmig_pkg::pos_t                 cur;
  cmig_pkg::pos_t                 state;
  cmig_pkg::part_t                part;
  logic                           last;
  logic                           accept;
  logic [cmig_pkg::VTX_W-1:0]     v0;
  logic [cmig_pkg::VTX_W-1:0]     v1;
  logic [cmig_pkg::VTX_W-1:0]     v2;

  // Result register.
  logic                           out_valid;
  logic [cmig_pkg::VTX_W-1:0]     out_first;
  logic [cmig_pkg::VTX_W-1:0]     out_second;
  logic [cmig_pkg::VTX_W-1:0]     out_third;
  cmig_pkg::part_t                out_part;
  logic                           out_last;

  cmig_cfg #(
    .MAX_RINGS  (MAX_RINGS),
    .MAX_SLICES (MAX_SLICES)
  ) u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .eff (eff)
  );

  // The walker advances only on an accepted request, so a stalled result
  // never loses or repeats a triangle.
  cmig_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .restart (req.restart),
    .cfg     (eff),
    .cur     (cur),
    .state   (state),
    .last    (last)
  );

  cmig_tri u_tri (
    .cur  (cur),
    .cfg  (eff),
    .v0   (v0),
    .v1   (v1),
    .v2   (v2),
    .part (part)
  );

  // A new request is taken whenever the result register frees up this cycle.
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_first  <= v0;
      out_second <= v1;
      out_third  <= v2;
      out_part   <= part;
      out_last   <= last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.first_vertex  = out_first;
  assign rsp.second_vertex = out_second;
  assign rsp.third_vertex  = out_third;
  assign rsp.mesh_part     = out_part;
  assign rsp.last_triangle = out_last;

  // The final triangle of the mesh always belongs to the top cap.
  `CMIG_ASSERT(a_last_on_top, clk, rst, !(out_valid && out_last) || out_part == cmig_pkg::PART_TOP)

  // A restart request yields the first side triangle, which starts at vertex zero.
  `CMIG_ASSERT_NEXT(a_restart_first, clk, rst, accept && req.restart, out_valid && out_first == '0)

  // After the final triangle the walk is back at the very start of the side.
  `CMIG_ASSERT_NEXT(a_wrap_clears, clk, rst, accept && last, state == cmig_pkg::POS_CLEAR)

endmodule

/* rtl/core/cmig_cfg.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator configuration registers
// Holds the count and direction registers and saturates the counts.
// ----------------------------------------------------------------------------
module cmig_cfg #(
  parameter int MAX_RINGS  = cmig_pkg::MAX_RINGS_DEF,
  parameter int MAX_SLICES = cmig_pkg::MAX_SLICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cmig_cfg_if.sink          cfg,
  output cmig_pkg::cfg_t    eff
);

  localparam logic [cmig_pkg::CNT_W-1:0] RING_MAX  = cmig_pkg::CNT_W'(MAX_RINGS);
  localparam logic [cmig_pkg::CNT_W-1:0] SLICE_MAX = cmig_pkg::CNT_W'(MAX_SLICES);

  logic [cmig_pkg::CNT_W-1:0] ring_count;
  logic [cmig_pkg::CNT_W-1:0] slice_count;
  logic                       length_negative;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count      <= cmig_pkg::RING_RESET;
      slice_count     <= cmig_pkg::SLICE_RESET;
      length_negative <= 1'b0;
    end else if (cfg.valid) begin
      case (cmig_pkg::cfg_reg_t'(cfg.index))
        cmig_pkg::CFG_RING_COUNT:      ring_count      <= cfg.data;
        cmig_pkg::CFG_SLICE_COUNT:     slice_count     <= cfg.data;
        cmig_pkg::CFG_LENGTH_NEGATIVE: length_negative <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range counts are clamped before any use.
  always_comb begin
    if (ring_count < cmig_pkg::RING_MIN) begin
      eff.rings = cmig_pkg::RING_MIN;
    end else if (ring_count > RING_MAX) begin
      eff.rings = RING_MAX;
    end else begin
      eff.rings = ring_count;
    end
    if (slice_count < cmig_pkg::SLICE_MIN) begin
      eff.slices = cmig_pkg::SLICE_MIN;
    end else if (slice_count > SLICE_MAX) begin
      eff.slices = SLICE_MAX;
    end else begin
      eff.slices = slice_count;
    end
    eff.length_negative = length_negative;
  end

endmodule

/* rtl/core/cmig_walker.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator position walker
// Holds the mesh position and steps it by one triangle per request.
// ----------------------------------------------------------------------------
module cmig_walker (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            restart,
  input  cmig_pkg::cfg_t  cfg,
  output cmig_pkg::pos_t  cur,
  output cmig_pkg::pos_t  state,
  output logic            last
);

  cmig_pkg::pos_t                 state_next;
  logic                           slice_done;
  logic                           ring_done;
  logic [cmig_pkg::POS_W-1:0]     slice_inc;
  logic [cmig_pkg::VTX_W-1:0]     base_inc;

  always_comb begin
    cur = restart ? cmig_pkg::POS_CLEAR : state;

    slice_done = ({1'b0, cur.slice} + 8'd1) >= cfg.slices;
    ring_done  = ({1'b0, cur.ring} + 8'd1) >= (cfg.rings - 8'd1);
    slice_inc  = cur.slice + 7'd1;
    base_inc   = cur.base + cmig_pkg::VTX_W'(cfg.slices) + 16'd1;

    last       = (cur.part == cmig_pkg::PART_TOP) && slice_done;
    state_next = cur;

    case (cur.part)
      cmig_pkg::PART_BOTTOM, cmig_pkg::PART_TOP: begin
        if (slice_done) begin
          state_next.slice = '0;
          if (cur.part == cmig_pkg::PART_TOP) begin
            state_next = cmig_pkg::POS_CLEAR;
          end else begin
            state_next.part = cmig_pkg::PART_TOP;
          end
        end else begin
          state_next.slice = slice_inc;
        end
      end
      default: begin
        if (!cur.second_half) begin
          state_next.second_half = 1'b1;
        end else begin
          state_next.second_half = 1'b0;
          if (slice_done) begin
            state_next.slice = '0;
            if (ring_done) begin
              state_next.ring = '0;
              state_next.base = '0;
              state_next.part = cmig_pkg::PART_BOTTOM;
            end else begin
              state_next.ring = cur.ring + 7'd1;
              state_next.base = base_inc;
            end
          end else begin
            state_next.slice = slice_inc;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmig_pkg::POS_CLEAR;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/cmig_tri.sv */
// ----------------------------------------------------------------------------
// Cylinder mesh index generator triangle assembly
// Forms the three vertex indices of the triangle at the current position.
// ----------------------------------------------------------------------------
module cmig_tri (
  input  cmig_pkg::pos_t              cur,
  input  cmig_pkg::cfg_t              cfg,
  output logic [cmig_pkg::VTX_W-1:0]  v0,
  output logic [cmig_pkg::VTX_W-1:0]  v1,
  output logic [cmig_pkg::VTX_W-1:0]  v2,
  output cmig_pkg::part_t             part
);

  logic [16:0]                    ring_span;
  logic [cmig_pkg::VTX_W-1:0]     c_bottom;
  logic [cmig_pkg::VTX_W-1:0]     c_top;
  logic [cmig_pkg::VTX_W-1:0]     center;
  logic [cmig_pkg::VTX_W-1:0]     slice16;
  logic [cmig_pkg::VTX_W-1:0]     near_v;
  logic [cmig_pkg::VTX_W-1:0]     far_v;
  logic [cmig_pkg::VTX_W-1:0]     a_i;
  logic [cmig_pkg::VTX_W-1:0]     b_i;
  logic                           reversed;

  // Cap centers sit right after the side vertices, one cap ring apart.
  assign ring_span = 17'(cfg.rings) * 17'({1'b0, cfg.slices} + 9'd1);
  assign c_bottom  = ring_span[cmig_pkg::VTX_W-1:0];
  assign c_top     = c_bottom + cmig_pkg::VTX_W'(cfg.slices) + 16'd2;
  assign slice16   = cmig_pkg::VTX_W'(cur.slice);

  assign center    = (cur.part == cmig_pkg::PART_TOP) ? c_top : c_bottom;
  assign reversed  = (cur.part == cmig_pkg::PART_TOP) ? cfg.length_negative
                                                      : !cfg.length_negative;
  assign near_v    = center + 16'd1 + slice16;
  assign far_v     = center + 16'd2 + slice16;

  // Side quad corners on the lower (a) and upper (b) ring.
  assign a_i = cur.base + slice16;
  assign b_i = cur.base + cmig_pkg::VTX_W'(cfg.slices) + 16'd1 + slice16;

  always_comb begin
    case (cur.part)
      cmig_pkg::PART_BOTTOM, cmig_pkg::PART_TOP: begin
        part = cur.part;
        v0   = center;
        v1   = reversed ? near_v : far_v;
        v2   = reversed ? far_v  : near_v;
      end
      default: begin
        part = cmig_pkg::PART_SIDE;
        v0   = cur.second_half ? (a_i + 16'd1) : a_i;
        v1   = b_i;
        v2   = cur.second_half ? (b_i + 16'd1) : (a_i + 16'd1);
      end
    endcase
  end

endmodule
